### src/mdm_pkg.sv
package mdm_pkg;

  // item field widths
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int KIND_W = 2;
  localparam int DIST_W = 8;
  localparam int CFG_W  = 7;

  // store geometry
  localparam int MAX_ROWS = 1 << ROW_W;
  localparam int MAX_COLS = 1 << COL_W;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;

  // widths of used-area sizes and of a summed distance
  localparam int HSZ_W = ROW_W + 1;
  localparam int WSZ_W = COL_W + 1;
  localparam int SUM_W = ((ROW_W > COL_W) ? ROW_W : COL_W) + 1;

  // cell kinds
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OWN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD   = 2'd3;

  // item modes (in_tuser)
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // register indexes
  localparam logic CFG_IDX_HEIGHT = 1'b0;
  localparam logic CFG_IDX_WIDTH  = 1'b1;

  localparam logic [DIST_W-1:0] DIST_NONE = '1;
  localparam logic [DIST_W-1:0] DIST_SAT  = 8'd127;

  typedef struct packed {
    logic ram_we;
    logic latch_query;
    logic scan_init;
    logic scan_step;
    logic load_result;
  } mdm_cmd_t;

  typedef struct packed {
    logic area_miss;
    logic cell_occupied;
    logic scan_last;
  } mdm_sts_t;

endpackage

### src/mdm_ram.sv
module mdm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/mdm_dp.sv
module mdm_dp import mdm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mdm_cmd_t                 cmd,
  output mdm_sts_t                 sts,
  input  logic [ROW_W-1:0]         in_row,
  input  logic [COL_W-1:0]         in_col,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  output logic signed [DIST_W-1:0] out_data
);

  logic [CFG_W-1:0]  grid_h_r, grid_w_r;
  logic [HSZ_W-1:0]  h_used;
  logic [WSZ_W-1:0]  w_used;

  logic [ROW_W-1:0]  qr_r, cnt_r_r, cmp_r_r;
  logic [COL_W-1:0]  qc_r, cnt_c_r, cmp_c_r;
  logic              cmp_vld_r;
  logic              found_r;
  logic [SUM_W-1:0]  best_r;
  logic [DIST_W-1:0] out_data_r;

  logic [ADDR_W-1:0] ram_addr;
  logic [KIND_W-1:0] ram_rdata;
  logic              ram_we;

  logic [ROW_W-1:0]  dr;
  logic [COL_W-1:0]  dc;
  logic [SUM_W-1:0]  cell_dist;
  logic              col_end;

  // used area, clamped to the store
  always_comb begin
    h_used = (grid_h_r > CFG_W'(MAX_ROWS)) ? HSZ_W'(MAX_ROWS) : HSZ_W'(grid_h_r);
    w_used = (grid_w_r > CFG_W'(MAX_COLS)) ? WSZ_W'(MAX_COLS) : WSZ_W'(grid_w_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_h_r <= CFG_W'(MAX_ROWS);
      grid_w_r <= CFG_W'(MAX_COLS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_HEIGHT: grid_h_r <= cfg_wdata;
        CFG_IDX_WIDTH:  grid_w_r <= cfg_wdata;
        default:        grid_h_r <= grid_h_r;
      endcase
    end
  end

  // one port: scan counters while scanning, input address otherwise
  assign ram_addr = cmd.scan_step ? {cnt_r_r, cnt_c_r} : {in_row, in_col};
  assign ram_we   = cmd.ram_we && (in_kind != KIND_RSVD);

  mdm_ram #(
    .WIDTH (KIND_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_kind),
    .rdata (ram_rdata)
  );

  assign col_end = ({1'b0, cnt_c_r} == w_used - WSZ_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.latch_query) begin
      qr_r <= in_row;
      qc_r <= in_col;
    end
    if (cmd.scan_init) begin
      cnt_r_r <= '0;
      cnt_c_r <= '0;
    end else if (cmd.scan_step) begin
      if (col_end) begin
        cnt_c_r <= '0;
        cnt_r_r <= cnt_r_r + ROW_W'(1);
      end else begin
        cnt_c_r <= cnt_c_r + COL_W'(1);
      end
    end
    cmp_r_r <= cnt_r_r;
    cmp_c_r <= cnt_c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_step;
    end
  end

  // distance of the cell whose kind is on the ram output
  always_comb begin
    dr        = (cmp_r_r > qr_r) ? cmp_r_r - qr_r : qr_r - cmp_r_r;
    dc        = (cmp_c_r > qc_r) ? cmp_c_r - qc_r : qc_r - cmp_c_r;
    cell_dist = SUM_W'(dr) + SUM_W'(dc);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      found_r <= 1'b0;
    end else if (cmp_vld_r && (ram_rdata == KIND_TARGET) &&
                 (!found_r || cell_dist < best_r)) begin
      found_r <= 1'b1;
      best_r  <= cell_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      if (!found_r) begin
        out_data_r <= DIST_NONE;
      end else if (DIST_W'(best_r) > DIST_SAT) begin
        out_data_r <= DIST_SAT;
      end else begin
        out_data_r <= DIST_W'(best_r);
      end
    end
  end

  assign out_data = out_data_r;

  always_comb begin
    sts.area_miss     = ({1'b0, qr_r} >= h_used) || ({1'b0, qc_r} >= w_used);
    sts.cell_occupied = (ram_rdata != KIND_EMPTY);
    sts.scan_last     = ({1'b0, cnt_r_r} == h_used - HSZ_W'(1)) && col_end;
  end

endmodule

### src/mdm_ctrl.sv
module mdm_ctrl import mdm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     in_mode,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  mdm_sts_t sts,
  output mdm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    out_valid_nxt   = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_QUERY) begin
            cmd.latch_query = 1'b1;
            state_nxt       = S_CHECK;
          end else begin
            cmd.ram_we = 1'b1;
          end
        end
      end
      S_CHECK: begin
        // queried cell kind is on the ram output now
        cmd.scan_init = 1'b1;
        if (sts.area_miss || sts.cell_occupied) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_result = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ram_we |-> (state_r == S_IDLE) && !cmd.scan_step)
    else $error("cell write outside idle");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && sts.scan_last |=> (state_r == S_DRAIN))
    else $error("scan did not end after the last cell");

  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |=> (state_r == S_SCAN) || (state_r == S_FINISH))
    else $error("query check went astray");

endmodule

### src/manhattan_distance_map_unit.sv
// channel   dir   handshake             payload
// in_       in    in_tvalid/in_tready   in_tuser: mode; in_tdata: row, col, cell_kind
// out_      out   out_tvalid/out_tready out_tdata: distance (signed, -1 = none)
// cfg_      in    cfg_we                cfg_index 0 height, 1 width; cfg_wdata
//
// a write item is stored as it is accepted; a query passes through the check, scan,
// drain and finish states, skipping the scan when the cell is outside the area or
// occupied; the single port of the cell ram reads one cell a cycle during the scan
// synchronous active-low reset sets the area to 64 by 64; the cell store is not cleared
// a finished result sits in the output register while the next item is accepted;
// a later query holds in its last cycle until that result is taken
module manhattan_distance_map_unit import mdm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // input items
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [15:0]              in_tdata,   // row [5:0], col [11:6], cell_kind [13:12]
  input  logic                     in_tuser,   // mode
  // result items
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic signed [DIST_W-1:0] out_tdata,  // distance
  // configuration
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  mdm_cmd_t cmd;
  mdm_sts_t sts;

  // unpack the input item
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [KIND_W-1:0] in_kind;
  logic [1:0]        in_pad;

  assign in_row  = in_tdata[ROW_W-1:0];
  assign in_col  = in_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_kind = in_tdata[ROW_W+COL_W+KIND_W-1:ROW_W+COL_W];
  assign in_pad  = in_tdata[15:ROW_W+COL_W+KIND_W];

  // controller: handshakes and scan sequence
  mdm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser ^ (^in_pad & 1'b0)),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: cell ram, scan counters, running minimum, result register
  mdm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_kind   (in_kind),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_tdata)
  );

endmodule
